// ===== hdl/obt_pkg.sv =====
// Package with shared constants, command codes and the entry record of the order tables.
package obt_pkg;

  localparam int BOOK_DEPTH_DEF = 20;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_MODIFY = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] price;
    logic [31:0] qty;
    logic        kind;
    logic [63:0] venue;
    logic [63:0] symbol;
    logic [63:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Keeps the packed text up to its first zero byte and clears everything above it.
  function automatic logic [63:0] cut_text(input logic [63:0] code);
    logic [63:0] kept;
    logic        live;
    kept = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (code[8*b +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        kept[8*b +: 8] = code[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

// ===== hdl/order_book_table_core.sv =====
// Top level of the two-sided order table: command decode, table sequencer and result register.
//
// Commands arrive on the s_axis channel and each one yields exactly one
// result transaction on the m_axis channel. Bids occupy the lower half of
// one entry RAM and offers the upper half; every access goes through its
// single read port and single write port under a small sequencer.
// Add, clear and unused codes answer straight from the execute state; a read
// within the fill answers after one more RAM read state. Modify and remove scan
// the chosen table entry by entry (RAM read, then id compare) up to the first
// match or the last filled entry; remove then reads the last entry and writes
// it into the freed slot. The block takes a new command only when idle and the
// result register is empty or being drained in that cycle, so a stalled receiver
// holds the result and blocks further commands without losing any.
// Reset empties both tables at once; the RAM contents need no clearing.
module order_book_table_core #(
  parameter int BOOK_DEPTH = obt_pkg::BOOK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // order_id, order_price, order_quantity, venue_code, symbol_code, order_time, read_index
  input  logic [295:0] s_axis_tdata,
  // cmd, side, order_kind
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bid_count, offer_count, out_id, out_price, out_quantity, out_venue, out_symbol,
  // out_time, zero fill
  output logic [303:0] m_axis_tdata,
  // success, out_kind
  output logic [1:0]   m_axis_tuser
);

  localparam int FW    = $clog2(BOOK_DEPTH + 1);
  localparam int SLOTS = 2 * BOOK_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_CMP, ST_LAST_RD, ST_LAST_WR, ST_RD_WAIT
  } state_t;

  state_t              state;
  logic [2:0]          cmd;
  logic                side;
  logic [7:0]          ridx;
  obt_pkg::entry_t     req;
  logic [FW-1:0]       bid_fill;
  logic [FW-1:0]       offer_fill;
  logic [FW-1:0]       idx;
  logic                success;
  obt_pkg::entry_t     out_entry;

  logic                we;
  logic [AW-1:0]       waddr;
  obt_pkg::entry_t     wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  obt_pkg::entry_t     rdata;
  logic [FW-1:0]       sel_fill;
  logic                order_ok;

  function automatic logic [AW-1:0] slot(input logic is_bid, input logic [8:0] pos);
    logic [8:0] base;
    base = is_bid ? 9'd0 : 9'(BOOK_DEPTH);
    return AW'(pos + base);
  endfunction

  obt_ram #(
    .WIDTH (obt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sel_fill = side ? bid_fill : offer_fill;
  assign order_ok = (req.qty != 32'd0) && (req.kind || (req.price != 32'd0)) &&
                    (req.venue != 64'd0) && (req.symbol != 64'd0);

  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    we    = 1'b0;
    waddr = slot(side, 9'(idx));
    wdata = rdata;
    re    = 1'b0;
    raddr = slot(side, 9'(idx));
    unique case (state)
      ST_EXEC: begin
        if (cmd == obt_pkg::CMD_ADD) begin
          we    = (sel_fill != FW'(BOOK_DEPTH)) && order_ok;
          waddr = slot(side, 9'(sel_fill));
          wdata = req;
        end
        if (cmd == obt_pkg::CMD_READ) begin
          re    = 9'(ridx) < 9'(sel_fill);
          raddr = slot(side, 9'(ridx));
        end
      end
      ST_SCAN: re = 1'b1;
      ST_CMP: begin
        wdata.qty = req.qty;
        we = (cmd == obt_pkg::CMD_MODIFY) && (rdata.ident == req.ident) && !req.qty[31];
      end
      ST_LAST_RD: begin
        re    = 1'b1;
        raddr = slot(side, 9'(sel_fill) - 9'd1);
      end
      ST_LAST_WR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bid_fill      <= '0;
      offer_fill    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd        <= s_axis_tuser[2:0];
            side       <= s_axis_tuser[3];
            req.kind   <= s_axis_tuser[4];
            req.ident  <= s_axis_tdata[31:0];
            req.price  <= s_axis_tdata[63:32];
            req.qty    <= s_axis_tdata[95:64];
            req.venue  <= obt_pkg::cut_text(s_axis_tdata[159:96]);
            req.symbol <= obt_pkg::cut_text(s_axis_tdata[223:160]);
            req.stamp  <= s_axis_tdata[287:224];
            ridx       <= s_axis_tdata[295:288];
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          idx       <= '0;
          out_entry <= '0;
          success   <= 1'b0;
          state     <= ST_IDLE;
          m_axis_tvalid <= 1'b1;
          unique case (cmd)
            obt_pkg::CMD_ADD: begin
              if (we) begin
                success <= 1'b1;
                if (side) begin
                  bid_fill <= bid_fill + FW'(1);
                end else begin
                  offer_fill <= offer_fill + FW'(1);
                end
              end
            end
            obt_pkg::CMD_MODIFY, obt_pkg::CMD_REMOVE: begin
              if (sel_fill != '0) begin
                state         <= ST_SCAN;
                m_axis_tvalid <= 1'b0;
              end
            end
            obt_pkg::CMD_CLEAR: begin
              bid_fill   <= '0;
              offer_fill <= '0;
              success    <= 1'b1;
            end
            obt_pkg::CMD_READ: begin
              if (re) begin
                state         <= ST_RD_WAIT;
                m_axis_tvalid <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: state <= ST_CMP;
        ST_CMP: begin
          if (rdata.ident == req.ident) begin
            if (cmd == obt_pkg::CMD_REMOVE) begin
              state <= ST_LAST_RD;
            end else begin
              success       <= 1'b1;
              state         <= ST_IDLE;
              m_axis_tvalid <= 1'b1;
            end
          end else if (idx + FW'(1) == sel_fill) begin
            state         <= ST_IDLE;
            m_axis_tvalid <= 1'b1;
          end else begin
            idx   <= idx + FW'(1);
            state <= ST_SCAN;
          end
        end
        ST_LAST_RD: state <= ST_LAST_WR;
        ST_LAST_WR: begin
          if (side) begin
            bid_fill <= bid_fill - FW'(1);
          end else begin
            offer_fill <= offer_fill - FW'(1);
          end
          success       <= 1'b1;
          state         <= ST_IDLE;
          m_axis_tvalid <= 1'b1;
        end
        ST_RD_WAIT: begin
          out_entry     <= rdata;
          success       <= 1'b1;
          state         <= ST_IDLE;
          m_axis_tvalid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, out_entry.stamp, out_entry.symbol, out_entry.venue,
                         out_entry.qty, out_entry.price, out_entry.ident,
                         5'(offer_fill), 5'(bid_fill)};
  assign m_axis_tuser = {out_entry.kind, success};

endmodule

// ===== hdl/obt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module obt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
